### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define CHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true
`define CHT_ASSERT_NEVER(lbl, expr, msg) \
    `CHT_ASSERT(lbl, !(expr), msg)

`endif

### design/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants, types and helpers for the cache hit/miss tracker.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int COUNT_W    = 32;
    localparam int SIZE_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAPPING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd7;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 4'd12;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd12;

    typedef struct packed {
        logic wr_en;
        logic flush;
    } cht_ram_ctl_t;

    function automatic int flog2(input int n);
        int v;
        int b;
        v = n;
        b = 0;
        while (v > 1) begin
            b = b + 1;
            v = v >> 1;
        end
        return b;
    endfunction

endpackage

### design/cht_tag_ram.sv
// ----------------------------------------------------------------------------
// cht_tag_ram
// Line tag memory with registered read, plus per-line valid flops.
// ----------------------------------------------------------------------------
module cht_tag_ram
    import cht_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int TAG_W = 26
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cht_ram_ctl_t             ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [TAG_W-1:0]         wtag,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic                     rd_valid,
    output logic [TAG_W-1:0]         rd_tag
);

    logic [TAG_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [TAG_W-1:0] rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wtag;
        end
        rd_tag_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.flush)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_tag   = rd_tag_reg;

endmodule

### design/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl
// Lookup sequencer: walks candidate lines through one tag comparator,
// updates FIFO rings and saturating totals.
// ----------------------------------------------------------------------------
module cht_ctrl
    import cht_pkg::*;
#(
    parameter int MAX_LINES     = 64,
    parameter int LINE_BYTES    = 64,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [ADDRESS_WIDTH-1:0]                   address,
    input  logic                                       access_kind,
    input  logic [$clog2(MAX_LINES+1)-1:0]             len,
    input  logic [$clog2(flog2(MAX_LINES)+1)-1:0]      ibits,
    input  logic                                       mapping,
    input  logic                                       split,
    input  logic                                       flush,
    output logic                                       busy,
    output logic                                       done,
    output logic                                       hit,
    output logic                                       evicted,
    output logic [COUNT_W-1:0]                         access_total,
    output logic [COUNT_W-1:0]                         hit_total,
    output logic [COUNT_W-1:0]                         evict_total,
    output cht_ram_ctl_t                               ram_ctl,
    output logic [$clog2(MAX_LINES)-1:0]               raddr,
    output logic [$clog2(MAX_LINES)-1:0]               waddr,
    output logic [ADDRESS_WIDTH-flog2(LINE_BYTES)-1:0] wtag,
    input  logic                                       rd_valid,
    input  logic [ADDRESS_WIDTH-flog2(LINE_BYTES)-1:0] rd_tag
);

    localparam int OFF_BITS = flog2(LINE_BYTES);
    localparam int TAG_W    = ADDRESS_WIDTH - OFF_BITS;
    localparam int AW       = $clog2(MAX_LINES);
    localparam int LW       = $clog2(MAX_LINES + 1);
    localparam int IBW      = $clog2(flog2(MAX_LINES) + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [ADDRESS_WIDTH-1:0] addr_reg, addr_next;
    logic                     kind_reg, kind_next;
    logic                     half_reg, half_next;
    logic [AW-1:0]            base_reg, base_next;
    logic [TAG_W-1:0]         tag_reg, tag_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic                     full_reg, full_next;
    logic [AW-1:0]            start_pos_reg, start_pos_next;
    logic [LW-1:0]            used_reg, used_next;
    logic [LW-1:0]            i_reg, i_next;
    logic                     pend_reg, pend_next;
    logic                     last_valid_reg, last_valid_next;
    logic [AW-1:0]            wslot_reg, wslot_next;
    logic                     hit_reg, hit_next;
    logic                     evict_reg, evict_next;
    logic                     done_reg, done_next;
    logic [COUNT_W-1:0]       acc_cnt_reg, acc_cnt_next;
    logic [COUNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]       evc_cnt_reg, evc_cnt_next;
    logic [AW-1:0]            ring_head_reg [2];
    logic [AW-1:0]            ring_head_next [2];
    logic [AW-1:0]            ring_tail_reg [2];
    logic [AW-1:0]            ring_tail_next [2];
    logic [1:0]               ring_full_reg, ring_full_next;

    logic                     half_c;
    logic [AW-1:0]            base_c;
    logic [TAG_W-1:0]         line_addr_c;
    logic [IBW-1:0]           ibits_c;
    logic [TAG_W-1:0]         tag_c;
    logic [AW-1:0]            idx_c;
    logic [AW-1:0]            head_c;
    logic [AW-1:0]            tail_c;
    logic                     full_c;
    logic [LW-1:0]            used_c;
    logic [LW:0]              pos_sum_c;
    logic [AW-1:0]            pos_c;
    logic                     issue_c;
    logic                     match_c;
    logic [LW-1:0]            head_p1_c;
    logic [LW-1:0]            tail_p1_c;
    logic [AW-1:0]            head_inc_c;
    logic [AW-1:0]            tail_inc_c;
    logic [AW-1:0]            new_head_c;

    always_comb
    begin
        half_c      = split & kind_reg;
        base_c      = half_c ? AW'(len) : '0;
        line_addr_c = addr_reg[ADDRESS_WIDTH-1:OFF_BITS];
        ibits_c     = mapping ? '0 : ibits;
        tag_c       = line_addr_c >> ibits_c;
        idx_c       = line_addr_c[AW-1:0] & ~({AW{1'b1}} << ibits_c);
        head_c      = ring_head_reg[half_c];
        tail_c      = ring_tail_reg[half_c];
        full_c      = ring_full_reg[half_c];
        if (full_c)
        begin
            used_c = len;
        end
        else if (tail_c >= head_c)
        begin
            used_c = LW'(tail_c) - LW'(head_c);
        end
        else
        begin
            used_c = LW'(tail_c) + len - LW'(head_c);
        end

        pos_sum_c = (LW+1)'(start_pos_reg) + (LW+1)'(i_reg);
        if (pos_sum_c >= (LW+1)'(len))
        begin
            pos_c = AW'(pos_sum_c - (LW+1)'(len));
        end
        else
        begin
            pos_c = AW'(pos_sum_c);
        end
        issue_c = (i_reg < used_reg);
        match_c = rd_valid && (rd_tag == tag_reg);

        head_p1_c  = LW'(head_reg) + LW'(1);
        tail_p1_c  = LW'(tail_reg) + LW'(1);
        head_inc_c = (head_p1_c == len) ? '0 : AW'(head_p1_c);
        tail_inc_c = (tail_p1_c == len) ? '0 : AW'(tail_p1_c);
        new_head_c = full_reg ? head_inc_c : head_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        kind_next       = kind_reg;
        half_next       = half_reg;
        base_next       = base_reg;
        tag_next        = tag_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        full_next       = full_reg;
        start_pos_next  = start_pos_reg;
        used_next       = used_reg;
        i_next          = i_reg;
        pend_next       = pend_reg;
        last_valid_next = last_valid_reg;
        wslot_next      = wslot_reg;
        hit_next        = hit_reg;
        evict_next      = evict_reg;
        done_next       = 1'b0;
        acc_cnt_next    = acc_cnt_reg;
        hit_cnt_next    = hit_cnt_reg;
        evc_cnt_next    = evc_cnt_reg;
        ring_head_next  = ring_head_reg;
        ring_tail_next  = ring_tail_reg;
        ring_full_next  = ring_full_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    addr_next  = address;
                    kind_next  = access_kind;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                half_next      = half_c;
                base_next      = base_c;
                tag_next       = tag_c;
                head_next      = head_c;
                tail_next      = tail_c;
                full_next      = full_c;
                start_pos_next = mapping ? head_c : idx_c;
                used_next      = mapping ? used_c : LW'(1);
                wslot_next     = base_c + (mapping ? tail_c : idx_c);
                i_next         = '0;
                pend_next      = 1'b0;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                pend_next = issue_c;
                if (issue_c)
                begin
                    i_next = i_reg + LW'(1);
                end
                if (pend_reg)
                begin
                    last_valid_next = rd_valid;
                end
                if (pend_reg && match_c)
                begin
                    hit_next   = 1'b1;
                    evict_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if (!issue_c && !pend_reg)
                begin
                    hit_next   = 1'b0;
                    evict_next = mapping ? full_reg : last_valid_reg;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!hit_reg && mapping)
                begin
                    ring_head_next[half_reg] = new_head_c;
                    ring_tail_next[half_reg] = tail_inc_c;
                    ring_full_next[half_reg] = (tail_inc_c == new_head_c);
                end
                if (acc_cnt_reg != '1)
                begin
                    acc_cnt_next = acc_cnt_reg + COUNT_W'(1);
                end
                if (hit_reg && hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
                end
                if (evict_reg && evc_cnt_reg != '1)
                begin
                    evc_cnt_next = evc_cnt_reg + COUNT_W'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (flush)
        begin
            ring_head_next = '{default: '0};
            ring_tail_next = '{default: '0};
            ring_full_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            kind_reg       <= 1'b0;
            half_reg       <= 1'b0;
            base_reg       <= '0;
            tag_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            full_reg       <= 1'b0;
            start_pos_reg  <= '0;
            used_reg       <= '0;
            i_reg          <= '0;
            pend_reg       <= 1'b0;
            last_valid_reg <= 1'b0;
            wslot_reg      <= '0;
            hit_reg        <= 1'b0;
            evict_reg      <= 1'b0;
            done_reg       <= 1'b0;
            acc_cnt_reg    <= '0;
            hit_cnt_reg    <= '0;
            evc_cnt_reg    <= '0;
            ring_head_reg  <= '{default: '0};
            ring_tail_reg  <= '{default: '0};
            ring_full_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            kind_reg       <= kind_next;
            half_reg       <= half_next;
            base_reg       <= base_next;
            tag_reg        <= tag_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            full_reg       <= full_next;
            start_pos_reg  <= start_pos_next;
            used_reg       <= used_next;
            i_reg          <= i_next;
            pend_reg       <= pend_next;
            last_valid_reg <= last_valid_next;
            wslot_reg      <= wslot_next;
            hit_reg        <= hit_next;
            evict_reg      <= evict_next;
            done_reg       <= done_next;
            acc_cnt_reg    <= acc_cnt_next;
            hit_cnt_reg    <= hit_cnt_next;
            evc_cnt_reg    <= evc_cnt_next;
            ring_head_reg  <= ring_head_next;
            ring_tail_reg  <= ring_tail_next;
            ring_full_reg  <= ring_full_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign evicted       = evict_reg;
    assign access_total  = acc_cnt_reg;
    assign hit_total     = hit_cnt_reg;
    assign evict_total   = evc_cnt_reg;
    assign raddr         = base_reg + pos_c;
    assign waddr         = wslot_reg;
    assign wtag          = tag_reg;
    assign ram_ctl.wr_en = (state_reg == S_FINISH) && !hit_reg;
    assign ram_ctl.flush = flush;

endmodule

### design/cache_hit_miss_tracker_unit.sv
// An accepted start captures the address and kind, SETUP latches the ring state and tag,
// SCAN compares stored lines, and FINISH updates rings and totals and registers done.
// A single tag comparator scans one stored line per cycle.
// One access at a time; busy drops in the done cycle, so the next one may start there.
// done cannot be stalled. Reset: lines invalid, rings empty, totals zero, 4 KB unified direct.
// ----------------------------------------------------------------------------
// cache_hit_miss_tracker_unit
// Tag-only cache model: direct mapped or FIFO fully associative, unified
// or split I/D, with hit/evict flags and saturating totals.
// ----------------------------------------------------------------------------
module cache_hit_miss_tracker_unit
    import cht_pkg::*;
#(
    parameter int MAX_LINES     = 64,
    parameter int LINE_BYTES    = 64,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ADDRESS_WIDTH-1:0] address,
    input  logic                     access_kind,
    output logic                     done,
    output logic                     hit,
    output logic                     evicted,
    output logic [COUNT_W-1:0]       access_total,
    output logic [COUNT_W-1:0]       hit_total,
    output logic [COUNT_W-1:0]       evict_total,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int OFF_BITS = flog2(LINE_BYTES);
    localparam int TAG_W    = ADDRESS_WIDTH - OFF_BITS;
    localparam int AW       = $clog2(MAX_LINES);
    localparam int LW       = $clog2(MAX_LINES + 1);
    localparam int IBW      = $clog2(flog2(MAX_LINES) + 1);

    function automatic int len_for(input int s, input int sp);
        int n;
        n = (1 << s) / LINE_BYTES;
        if (sp != 0)
        begin
            n = n >> 1;
            if (n > (MAX_LINES >> 1))
            begin
                n = MAX_LINES >> 1;
            end
        end
        else if (n > MAX_LINES)
        begin
            n = MAX_LINES;
        end
        if (n < 1)
        begin
            n = 1;
        end
        return n;
    endfunction

    localparam int LEN_U [6] = '{len_for(7, 0), len_for(8, 0), len_for(9, 0),
                                 len_for(10, 0), len_for(11, 0), len_for(12, 0)};
    localparam int LEN_S [6] = '{len_for(7, 1), len_for(8, 1), len_for(9, 1),
                                 len_for(10, 1), len_for(11, 1), len_for(12, 1)};
    localparam int IDX_U [6] = '{flog2(LEN_U[0]), flog2(LEN_U[1]), flog2(LEN_U[2]),
                                 flog2(LEN_U[3]), flog2(LEN_U[4]), flog2(LEN_U[5])};
    localparam int IDX_S [6] = '{flog2(LEN_S[0]), flog2(LEN_S[1]), flog2(LEN_S[2]),
                                 flog2(LEN_S[3]), flog2(LEN_S[4]), flog2(LEN_S[5])};

    logic [SIZE_W-1:0] size_reg, size_next;
    logic              mapping_reg, mapping_next;
    logic              split_reg, split_next;
    logic              cfg_beat;
    logic              flush;
    logic [SIZE_W-1:0] size_c;
    logic [2:0]        geo_idx;
    logic [LW-1:0]     len;
    logic [IBW-1:0]    ibits;

    cht_ram_ctl_t      ram_ctl;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [TAG_W-1:0]  wtag;
    logic              rd_valid;
    logic [TAG_W-1:0]  rd_tag;

    assign cfg_ready = !busy;
    assign cfg_beat  = cfg_valid && cfg_ready;

    always_comb
    begin
        size_next    = size_reg;
        mapping_next = mapping_reg;
        split_next   = split_reg;
        flush        = 1'b0;
        if (cfg_beat)
        begin
            case (cfg_index)
                REG_SIZE_LOG2:
                begin
                    size_next = cfg_data;
                    flush     = 1'b1;
                end
                REG_MAPPING:
                begin
                    mapping_next = cfg_data[0];
                    flush        = 1'b1;
                end
                REG_SPLIT:
                begin
                    split_next = cfg_data[0];
                    flush      = 1'b1;
                end
                default:
                begin
                    flush = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SIZE_RESET;
            mapping_reg <= 1'b0;
            split_reg   <= 1'b0;
        end
        else
        begin
            size_reg    <= size_next;
            mapping_reg <= mapping_next;
            split_reg   <= split_next;
        end
    end

    always_comb
    begin
        if (size_reg < SIZE_MIN)
        begin
            size_c = SIZE_MIN;
        end
        else if (size_reg > SIZE_MAX)
        begin
            size_c = SIZE_MAX;
        end
        else
        begin
            size_c = size_reg;
        end
        geo_idx = 3'(size_c - SIZE_MIN);
        if (split_reg)
        begin
            len   = LW'(LEN_S[geo_idx]);
            ibits = IBW'(IDX_S[geo_idx]);
        end
        else
        begin
            len   = LW'(LEN_U[geo_idx]);
            ibits = IBW'(IDX_U[geo_idx]);
        end
    end

    cht_ctrl #(
        .MAX_LINES     (MAX_LINES),
        .LINE_BYTES    (LINE_BYTES),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .address      (address),
        .access_kind  (access_kind),
        .len          (len),
        .ibits        (ibits),
        .mapping      (mapping_reg),
        .split        (split_reg),
        .flush        (flush),
        .busy         (busy),
        .done         (done),
        .hit          (hit),
        .evicted      (evicted),
        .access_total (access_total),
        .hit_total    (hit_total),
        .evict_total  (evict_total),
        .ram_ctl      (ram_ctl),
        .raddr        (raddr),
        .waddr        (waddr),
        .wtag         (wtag),
        .rd_valid     (rd_valid),
        .rd_tag       (rd_tag)
    );

    cht_tag_ram #(
        .DEPTH (MAX_LINES),
        .TAG_W (TAG_W)
    ) u_tag_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ram_ctl),
        .waddr    (waddr),
        .wtag     (wtag),
        .raddr    (raddr),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag)
    );

endmodule

### design/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the tracker's command and result behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cht_checker
    import cht_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               hit,
    input logic               evicted,
    input logic [COUNT_W-1:0] access_total,
    input logic [COUNT_W-1:0] hit_total,
    input logic [COUNT_W-1:0] evict_total
);

    `CHT_ASSERT_NEVER(a_hit_and_evict, done && hit && evicted, "hit beat flagged an eviction")
    `CHT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
    `CHT_ASSERT(a_hits_bounded, done |-> (hit_total <= access_total), "hits above accesses")
    `CHT_ASSERT(a_evicts_bounded, done |-> (evict_total <= access_total), "evicts above accesses")
    `CHT_ASSERT(a_result_counted, done |-> (access_total != '0), "result beat with no accesses")

endmodule

bind cache_hit_miss_tracker_unit cht_checker u_cht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .evicted      (evicted),
    .access_total (access_total),
    .hit_total    (hit_total),
    .evict_total  (evict_total)
);

### bench/cht_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_access_checker
// Watches the access, result and register channels of the hit/miss tracker.
// Keeps its own copy of the tag store, FIFO rings, totals and register values.
// Predicts the outcome of every accepted access and compares each done beat,
// field by field, with the oldest prediction. It counts mismatches and
// reports how many predictions are still waiting.
// ----------------------------------------------------------------------------
module cht_access_checker
    import cht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [31:0]           address,
    input  logic                  access_kind,
    input  logic                  done,
    input  logic                  hit,
    input  logic                  evicted,
    input  logic [COUNT_W-1:0]    access_total,
    input  logic [COUNT_W-1:0]    hit_total,
    input  logic [COUNT_W-1:0]    evict_total,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    localparam int NUM_LINES   = 64;
    localparam int OFFSET_BITS = 6;
    localparam int TAG_W       = 26;

    typedef struct packed {
        logic               hit;
        logic               evicted;
        logic [COUNT_W-1:0] accesses;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] evictions;
    } access_outcome_t;

    logic [SIZE_W-1:0]  size_reg;
    logic               mapping_reg;
    logic               split_reg;
    logic               line_valid [NUM_LINES];
    logic [TAG_W-1:0]   line_tag [NUM_LINES];
    logic [5:0]         ring_head [2];
    logic [5:0]         ring_tail [2];
    logic               ring_full [2];
    logic [COUNT_W-1:0] access_cnt;
    logic [COUNT_W-1:0] hit_cnt;
    logic [COUNT_W-1:0] evict_cnt;
    access_outcome_t    outcome_q [$];
    access_outcome_t    want;

    initial mismatches = 0;
    initial pending = 0;

    function automatic void flush_lines();
        for (int i = 0; i < NUM_LINES; i++)
            line_valid[i] = 1'b0;
        for (int h = 0; h < 2; h++)
        begin
            ring_head[h] = '0;
            ring_tail[h] = '0;
            ring_full[h] = 1'b0;
        end
    endfunction

    function automatic access_outcome_t lookup_access(input logic [31:0] addr,
                                                      input logic kind);
        int               sl;
        int               len;
        int               cap;
        int               half;
        int               idx_bits;
        int               n;
        int               base;
        int               slot;
        int               head;
        int               tail;
        int               used;
        int               i;
        logic [TAG_W-1:0] tag;
        logic             is_hit;
        logic             is_evict;
        access_outcome_t  res;

        sl = (size_reg < SIZE_MIN) ? SIZE_MIN : ((size_reg > SIZE_MAX) ? SIZE_MAX : size_reg);
        len = (1 << sl) / 64;
        cap = split_reg ? NUM_LINES / 2 : NUM_LINES;
        half = split_reg ? int'(kind) : 0;
        if (split_reg)
            len = len / 2;
        if (len > cap)
            len = cap;
        if (len < 1)
            len = 1;
        base = half * len;

        idx_bits = 0;
        if (!mapping_reg)
            for (n = len; n > 1; n = n >> 1)
                idx_bits++;
        tag = TAG_W'(addr >> (OFFSET_BITS + idx_bits));
        is_hit = 1'b0;
        is_evict = 1'b0;

        if (!mapping_reg)
        begin
            slot = (base + int'((addr >> OFFSET_BITS) & ((32'd1 << idx_bits) - 1))) % NUM_LINES;
            if (line_valid[slot] && line_tag[slot] == tag)
                is_hit = 1'b1;
            else
            begin
                is_evict = line_valid[slot];
                line_valid[slot] = 1'b1;
                line_tag[slot] = tag;
            end
        end
        else
        begin
            head = int'(ring_head[half]) % len;
            tail = int'(ring_tail[half]) % len;
            used = ring_full[half] ? len : (tail + len - head) % len;
            for (i = 0; i < used && !is_hit; i++)
            begin
                slot = (base + (head + i) % len) % NUM_LINES;
                if (line_valid[slot] && line_tag[slot] == tag)
                    is_hit = 1'b1;
            end
            if (!is_hit)
            begin
                if (ring_full[half])
                begin
                    head = (head + 1) % len;
                    is_evict = 1'b1;
                end
                slot = (base + tail) % NUM_LINES;
                line_valid[slot] = 1'b1;
                line_tag[slot] = tag;
                tail = (tail + 1) % len;
                ring_full[half] = (tail == head);
            end
            ring_head[half] = 6'(head);
            ring_tail[half] = 6'(tail);
        end

        // totals hold at all ones
        if (access_cnt != '1)
            access_cnt++;
        if (is_hit && hit_cnt != '1)
            hit_cnt++;
        if (is_evict && evict_cnt != '1)
            evict_cnt++;

        res.hit = is_hit;
        res.evicted = is_evict;
        res.accesses = access_cnt;
        res.hits = hit_cnt;
        res.evictions = evict_cnt;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = SIZE_RESET;
            mapping_reg = 1'b0;
            split_reg = 1'b0;
            flush_lines();
            access_cnt = '0;
            hit_cnt = '0;
            evict_cnt = '0;
            outcome_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing outstanding: hit=%0b evicted=%0b",
                                 $time, hit, evicted);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (hit !== want.hit || evicted !== want.evicted ||
                        access_total !== want.accesses || hit_total !== want.hits ||
                        evict_total !== want.evictions)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected hit=%0b evicted=%0b ",
                                      "totals=%0d/%0d/%0d, got hit=%0b evicted=%0b ",
                                      "totals=%0d/%0d/%0d"},
                                     $time, want.hit, want.evicted, want.accesses,
                                     want.hits, want.evictions, hit, evicted,
                                     access_total, hit_total, evict_total);
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(lookup_access(address, access_kind));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIZE_LOG2:
                    begin
                        size_reg = cfg_data;
                        flush_lines();
                    end
                    REG_MAPPING:
                    begin
                        mapping_reg = cfg_data[0];
                        flush_lines();
                    end
                    REG_SPLIT:
                    begin
                        split_reg = cfg_data[0];
                        flush_lines();
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = outcome_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the cache hit/miss tracker.
// A directed pass covers address extremes, conflict evictions, both mappings,
// split and unified layouts, clamped sizes and a write to the spare register
// index. Random phases then reprogram the cache and issue accesses drawn
// mostly from a small line pool so hits and FIFO evictions occur often.
// ----------------------------------------------------------------------------
module tb;
    import cht_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [31:0]           address;
    logic                  access_kind;
    logic                  done;
    logic                  hit;
    logic                  evicted;
    logic [COUNT_W-1:0]    access_total;
    logic [COUNT_W-1:0]    hit_total;
    logic [COUNT_W-1:0]    evict_total;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         mismatches;
    int         pending;
    int         stall_cycles = 0;
    bit         gaps_on;
    int         sent;
    int         phase_len;
    int         hi_count;
    int         lo_span;
    int         pick;
    logic [31:0] addr;
    logic [19:0] hi_pool [4];

    cache_hit_miss_tracker_unit dut (.*);

    cht_access_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .address      (address),
        .access_kind  (access_kind),
        .done         (done),
        .hit          (hit),
        .evicted      (evicted),
        .access_total (access_total),
        .hit_total    (hit_total),
        .evict_total  (evict_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_access(input logic [31:0] a, input logic k);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = !gaps_on ? 0 : (r < 65 ? 0 : (r < 92 ? $urandom_range(1, 4)
                                                    : $urandom_range(10, 90)));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        address <= a;
        access_kind <= k;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        address = '0;
        access_kind = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gaps_on = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset layout: direct mapped, unified, 64 lines
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_003F, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'h0000_1000, 1'b0);
        send_access(32'h0000_0000, 1'b0);
        // spare index must leave the lines alone
        wait_drained();
        write_reg(REG_SPARE, 4'hF);
        cfg_valid <= 1'b0;
        send_access(32'h0000_0000, 1'b0);

        // size below range, fully associative, split: one line per half
        wait_drained();
        write_reg(REG_SIZE_LOG2, 4'd0);
        write_reg(REG_MAPPING, 4'd1);
        write_reg(REG_SPLIT, 4'd1);
        cfg_valid <= 1'b0;
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0040, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0000, 1'b0);

        // four-line FIFO, unified
        wait_drained();
        write_reg(REG_SIZE_LOG2, 4'd8);
        write_reg(REG_SPLIT, 4'd0);
        cfg_valid <= 1'b0;
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0040, 1'b0);
        send_access(32'h0000_0080, 1'b1);
        send_access(32'h0000_00C0, 1'b0);
        send_access(32'h0000_0040, 1'b1);
        send_access(32'h0000_0100, 1'b0);
        send_access(32'h0000_0000, 1'b0);

        // size above range, direct mapped, split
        wait_drained();
        write_reg(REG_SIZE_LOG2, 4'd15);
        write_reg(REG_MAPPING, 4'd0);
        write_reg(REG_SPLIT, 4'd1);
        cfg_valid <= 1'b0;
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0800, 1'b0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            pick = $urandom_range(0, 5);
            case (pick)
                0: write_reg(REG_SIZE_LOG2, SIZE_MIN);
                1: write_reg(REG_SIZE_LOG2, SIZE_MAX);
                2: write_reg(REG_SIZE_LOG2, 4'd0);
                3: write_reg(REG_SIZE_LOG2, 4'd15);
                default: write_reg(REG_SIZE_LOG2, 4'($urandom));
            endcase
            write_reg(REG_MAPPING, 4'($urandom));
            write_reg(REG_SPLIT, 4'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, 4'($urandom));
            cfg_valid <= 1'b0;

            gaps_on = ($urandom_range(0, 4) != 0);
            hi_count = $urandom_range(1, 4);
            case ($urandom_range(0, 3))
                0: lo_span = 1;
                1: lo_span = 3;
                2: lo_span = 15;
                default: lo_span = 63;
            endcase
            for (int k = 0; k < 4; k++)
                hi_pool[k] = 20'($urandom);
            phase_len = $urandom_range(40, 140);

            repeat (phase_len)
            begin
                if ($urandom_range(0, 99) < 15)
                    addr = $urandom;
                else
                    addr = {hi_pool[$urandom_range(0, hi_count - 1)],
                            6'($urandom_range(0, lo_span)), 6'($urandom_range(0, 63))};
                send_access(addr, 1'($urandom_range(0, 1)));
                sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
